// ===== hdl/lfr_pkg.sv =====
`default_nettype none

package lfr_pkg;

    localparam int STORE_DEPTH     = 64;
    localparam int ADDR_W          = 6;
    localparam int LEN_W           = 7;
    localparam int SUM_W           = 17;
    localparam int DEF_MAX_PAYLOAD = 64;

    typedef enum logic [3:0] {
        ST_CMD_LO,
        ST_CMD_HI,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CHECK,
        ST_READ,
        ST_SHOW
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic ld_cmd_lo;
        logic ld_cmd_hi;
        logic ld_len_lo;
        logic ld_len_hi;
        logic ld_payload;
        logic ld_check;
        logic rd_issue;
        logic idx_step;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic len_over;
        logic len_zero;
        logic pay_done;
        logic chk_last;
        logic chk_match;
        logic len_empty;
        logic emit_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== hdl/lfr_ram.sv =====
`default_nettype none

module lfr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lfr_datapath.sv =====
`default_nettype none

module lfr_datapath #(
    parameter int MAX_PAYLOAD = lfr_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lfr_pkg::ctl_t             ctl,
    output lfr_pkg::sts_t                  sts,
    input  wire logic [7:0]                rx_byte,
    output logic [15:0]                    frame_cmd,
    output logic [lfr_pkg::LEN_W-1:0]      frame_length,
    output logic [7:0]                     payload_byte,
    output logic [lfr_pkg::ADDR_W-1:0]     byte_position,
    output logic                           byte_valid,
    output logic                           last
);
    import lfr_pkg::*;

    logic [15:0]       cmd_reg, cmd_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [23:0]       chk_reg, chk_next;
    logic [1:0]        chk_cnt_reg, chk_cnt_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [15:0]       len_full;
    logic [7:0]        ram_rdata;

    assign len_full = {rx_byte, len_lo_reg};

    always_comb
    begin
        cmd_next     = cmd_reg;
        len_lo_next  = len_lo_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        chk_next     = chk_reg;
        chk_cnt_next = chk_cnt_reg;
        idx_next     = idx_reg;
        if (ctl.ld_cmd_lo)
        begin
            cmd_next = {8'd0, rx_byte};
        end
        if (ctl.ld_cmd_hi)
        begin
            cmd_next = {rx_byte, cmd_reg[7:0]};
        end
        if (ctl.ld_len_lo)
        begin
            len_lo_next = rx_byte;
        end
        if (ctl.ld_len_hi)
        begin
            // an oversized length is dropped, only the count, check and index state restart
            if (!sts.len_over)
            begin
                len_next = len_full[LEN_W-1:0];
            end
            sum_next     = SUM_W'(cmd_reg) + SUM_W'(len_full[LEN_W-1:0]);
            cnt_next     = '0;
            chk_cnt_next = '0;
            idx_next     = '0;
        end
        if (ctl.ld_payload)
        begin
            sum_next = sum_reg + SUM_W'(rx_byte);
            cnt_next = cnt_reg + LEN_W'(1);
        end
        if (ctl.ld_check)
        begin
            case (chk_cnt_reg)
                2'd0:    chk_next[7:0]   = rx_byte;
                2'd1:    chk_next[15:8]  = rx_byte;
                2'd2:    chk_next[23:16] = rx_byte;
                default: chk_next        = chk_reg;
            endcase
            chk_cnt_next = chk_cnt_reg + 2'd1;
        end
        if (ctl.idx_step)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= '0;
            len_lo_reg  <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            chk_reg     <= '0;
            chk_cnt_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            cmd_reg     <= cmd_next;
            len_lo_reg  <= len_lo_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            chk_reg     <= chk_next;
            chk_cnt_reg <= chk_cnt_next;
            idx_reg     <= idx_next;
        end
    end

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.ld_payload),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (ctl.rd_issue),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.len_over  = len_full > 16'(MAX_PAYLOAD);
        sts.len_zero  = len_full == 16'd0;
        sts.pay_done  = (cnt_reg + LEN_W'(1)) == len_reg;
        sts.chk_last  = chk_cnt_reg == 2'd3;
        // sum stays below 2^17, so the upper check bits must be zero
        sts.chk_match = {rx_byte, chk_reg} == 32'(sum_reg);
        sts.len_empty = len_reg == '0;
        sts.emit_last = (len_reg == '0) || ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
    end

    assign frame_cmd     = cmd_reg;
    assign frame_length  = len_reg;
    assign byte_valid    = !sts.len_empty;
    assign payload_byte  = byte_valid ? ram_rdata : 8'd0;
    assign byte_position = idx_reg;
    assign last          = sts.emit_last;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_PAYLOAD)
        else $error("stored length above limit");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= len_reg)
        else $error("payload count ran past length");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(idx_reg) < MAX_PAYLOAD)
        else $error("emission index above limit");

endmodule

`default_nettype wire

// ===== hdl/lfr_ctrl.sv =====
`default_nettype none

module lfr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire lfr_pkg::sts_t sts,
    output lfr_pkg::ctl_t      ctl
);
    import lfr_pkg::*;

    state_t state_reg, state_next;
    logic   out_fire;

    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CMD_LO:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMD_HI;
                end
            end
            ST_CMD_HI:
            begin
                if (in_valid)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (in_valid)
                begin
                    state_next = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (in_valid)
                begin
                    if (sts.len_over)
                    begin
                        state_next = ST_CMD_LO;
                    end
                    else if (sts.len_zero)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD:
            begin
                if (in_valid && sts.pay_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_valid && sts.chk_last)
                begin
                    if (!sts.chk_match)
                    begin
                        state_next = ST_CMD_LO;
                    end
                    else if (sts.len_empty)
                    begin
                        state_next = ST_SHOW;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready)
                begin
                    state_next = sts.emit_last ? ST_CMD_LO : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CMD_LO;
            end
        endcase
    end

    // ready is constant within each state, so the loads follow valid directly
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        ctl       = '0;
        case (state_reg)
            ST_CMD_LO:
            begin
                in_ready      = 1'b1;
                ctl.ld_cmd_lo = in_valid;
            end
            ST_CMD_HI:
            begin
                in_ready      = 1'b1;
                ctl.ld_cmd_hi = in_valid;
            end
            ST_LEN_LO:
            begin
                in_ready      = 1'b1;
                ctl.ld_len_lo = in_valid;
            end
            ST_LEN_HI:
            begin
                in_ready      = 1'b1;
                ctl.ld_len_hi = in_valid;
            end
            ST_PAYLOAD:
            begin
                in_ready       = 1'b1;
                ctl.ld_payload = in_valid;
            end
            ST_CHECK:
            begin
                in_ready     = 1'b1;
                ctl.ld_check = in_valid;
            end
            ST_READ:
            begin
                ctl.rd_issue = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid    = 1'b1;
                ctl.idx_step = out_ready && !sts.emit_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CMD_LO;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during emission");

    a_read_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !sts.emit_last |=> !out_valid && ctl.rd_issue)
        else $error("next byte shown without a store read");

    a_drop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ld_check && sts.chk_last && !sts.chk_match |=> state_reg == ST_CMD_LO)
        else $error("bad frame not dropped");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.ld_cmd_lo, ctl.ld_cmd_hi, ctl.ld_len_lo, ctl.ld_len_hi,
                  ctl.ld_payload, ctl.ld_check, ctl.rd_issue, ctl.idx_step}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_frame_receiver_top.sv =====
`default_nettype none

// Frame receiver: takes one received byte per transaction on the input channel
// and assembles command (16 bits), length (16 bits), payload and a 32-bit
// additive check word, all low byte first. A length above MAX_PAYLOAD drops the
// frame right after the length; a check mismatch drops it silently. A good frame
// comes out as one transaction per payload byte with last on the final one, or
// as a single transaction with byte_valid low for an empty payload. Reception
// takes a byte whenever in_valid is high. Emission reads the 64-entry payload
// store through its registered read port, reading each byte in ST_READ before
// showing it; no input byte is taken while a frame is being emitted.
module length_prefixed_frame_receiver_top #(
    parameter int MAX_PAYLOAD = lfr_pkg::DEF_MAX_PAYLOAD
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                rx_byte,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [15:0]                    frame_cmd,
    output logic [lfr_pkg::LEN_W-1:0]      frame_length,
    output logic [7:0]                     payload_byte,
    output logic [lfr_pkg::ADDR_W-1:0]     byte_position,
    output logic                           byte_valid,
    output logic                           last
);
    import lfr_pkg::*;

    ctl_t ctl;
    sts_t sts;

    lfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lfr_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .rx_byte       (rx_byte),
        .frame_cmd     (frame_cmd),
        .frame_length  (frame_length),
        .payload_byte  (payload_byte),
        .byte_position (byte_position),
        .byte_valid    (byte_valid),
        .last          (last)
    );

endmodule

`default_nettype wire
